### hw/rtl/mles_pkg.sv
package mles_pkg;

  localparam int unsigned DefaultWidth = 32;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StNone = 2'd1,
    StZero = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SDivA,
    SDivB,
    SEucChk,
    SEucDiv,
    SEucMul,
    SChkDiv,
    SFinMul,
    SOut
  } state_e;

endpackage

### hw/rtl/mles_if.sv
// Request channel: congruence operands.
interface mles_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coeff_a;
  logic signed [31:0] rhs_b;
  logic signed [31:0] modulus;

  modport source (output valid, coeff_a, rhs_b, modulus, input ready);
  modport sink   (input valid, coeff_a, rhs_b, modulus, output ready);
endinterface

// Response channel: solution and status.
interface mles_rsp_if;
  logic        valid;
  logic        ready;
  logic [30:0] solution;
  logic [1:0]  status;

  modport source (output valid, solution, status, input ready);
  modport sink   (input valid, solution, status, output ready);
endinterface

### hw/rtl/modular_linear_equation_solver.sv
// Linear congruence solver: finds an x in [0, |m|) with a*x = b (mod |m|).
// Channels: req_i (sink) carries coeff_a, rhs_b, modulus; rsp_o (source)
// carries solution and status (ok, no solution, zero modulus). Both use
// valid/ready; a transaction completes when both are high at a clock edge.
// One transaction in gives exactly one transaction out.
// One restoring divider (one quotient bit per cycle) and one modular adder
// pair (one multiplier bit per cycle) are shared under a sequencer. It
// first reduces a and b by division; each Euclid step then takes a setup
// state, a division and a modular multiply; a final check division and,
// if it leaves no remainder, a final multiply follow, and the response is
// presented from the output register.
// A zero modulus is answered in the cycle after its request transaction.
// Throughput: one item at a time; req_i.ready is high only while idle.
// Reset clears the sequencer and the response valid; no item survives it.
// A stalled receiver holds the result in the output register, and the block
// takes no new item until that response transaction completes.
module modular_linear_equation_solver #(
  parameter int unsigned WIDTH = mles_pkg::DefaultWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mles_req_if.sink    req_i,
  mles_rsp_if.source  rsp_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  mles_pkg::state_e state_q, state_d;

  logic [WIDTH-1:0] m_q, m_d;
  logic [WIDTH-1:0] araw_q, araw_d;   // |a|, later reduced a
  logic [WIDTH-1:0] braw_q, braw_d;   // |b|, later reduced b
  logic             aneg_q, aneg_d;
  logic             bneg_q, bneg_d;
  logic [WIDTH-1:0] r0_q, r0_d, r1_q, r1_d;
  logic [WIDTH-1:0] s0_q, s0_d, s1_q, s1_d;
  // shared divider
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dv_q, dv_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  // shared modular multiply
  logic [WIDTH-1:0] mx_q, mx_d, my_q, my_d, acc_q, acc_d;
  // result
  logic [30:0]      sol_q, sol_d;
  mles_pkg::status_e st_q, st_d;

  // input magnitudes at WIDTH bits
  logic [WIDTH-1:0] in_a, in_b, in_m;
  logic [WIDTH-1:0] mag_a, mag_b, mag_m;

  // divider step
  logic [WIDTH:0]   div_sh;
  logic             div_ge;
  logic [WIDTH-1:0] div_rem, div_quo;
  logic             div_last;

  // modular adders
  logic [WIDTH:0]   add_acc, add_dbl;
  logic [WIDTH-1:0] acc_nx, dbl_nx;
  logic [WIDTH:0]   sub_res;
  logic [WIDTH-1:0] red_r, qmod;

  assign in_a  = WIDTH'(req_i.coeff_a);
  assign in_b  = WIDTH'(req_i.rhs_b);
  assign in_m  = WIDTH'(req_i.modulus);
  assign mag_a = in_a[WIDTH-1] ? (~in_a + 1'b1) : in_a;
  assign mag_b = in_b[WIDTH-1] ? (~in_b + 1'b1) : in_b;
  assign mag_m = in_m[WIDTH-1] ? (~in_m + 1'b1) : in_m;

  // restoring division, one quotient bit per cycle
  assign div_sh   = {rem_q, quo_q[WIDTH-1]};
  assign div_ge   = div_sh >= {1'b0, dv_q};
  assign div_rem  = div_ge ? WIDTH'(div_sh - {1'b0, dv_q}) : div_sh[WIDTH-1:0];
  assign div_quo  = {quo_q[WIDTH-2:0], div_ge};
  assign div_last = cnt_q == CntW'(WIDTH - 1);

  // (acc + mx) mod m and (mx + mx) mod m
  assign add_acc = {1'b0, acc_q} + {1'b0, mx_q};
  assign add_dbl = {1'b0, mx_q} + {1'b0, mx_q};
  assign acc_nx  = (add_acc >= {1'b0, m_q}) ? WIDTH'(add_acc - {1'b0, m_q})
                                            : add_acc[WIDTH-1:0];
  assign dbl_nx  = (add_dbl >= {1'b0, m_q}) ? WIDTH'(add_dbl - {1'b0, m_q})
                                            : add_dbl[WIDTH-1:0];
  // (s0 - acc) mod m
  assign sub_res = (s0_q >= acc_q) ? {1'b0, s0_q - acc_q}
                                   : {1'b0, s0_q} + {1'b0, m_q} - {1'b0, acc_q};

  // sign fix of a residue; quotient reduced mod m (q never exceeds m)
  always_comb begin
    red_r = div_rem;
    if (state_q == mles_pkg::SDivA) begin
      if (aneg_q && div_rem != '0) red_r = m_q - div_rem;
    end else begin
      if (bneg_q && div_rem != '0) red_r = m_q - div_rem;
    end
  end
  assign qmod = (div_quo >= m_q) ? div_quo - m_q : div_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mles_pkg::SIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    araw_q <= araw_d;
    braw_q <= braw_d;
    aneg_q <= aneg_d;
    bneg_q <= bneg_d;
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    s0_q   <= s0_d;
    s1_q   <= s1_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    acc_q  <= acc_d;
    sol_q  <= sol_d;
    st_q   <= st_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    m_d     = m_q;
    araw_d  = araw_q;
    braw_d  = braw_q;
    aneg_d  = aneg_q;
    bneg_d  = bneg_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    s0_d    = s0_q;
    s1_d    = s1_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dv_d    = dv_q;
    mx_d    = mx_q;
    my_d    = my_q;
    acc_d   = acc_q;
    sol_d   = sol_q;
    st_d    = st_q;

    req_i.ready = 1'b0;
    rsp_o.valid = 1'b0;

    unique case (state_q)
      mles_pkg::SIdle: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          m_d    = mag_m;
          araw_d = mag_a;
          braw_d = mag_b;
          aneg_d = in_a[WIDTH-1];
          bneg_d = in_b[WIDTH-1];
          if (mag_m == '0) begin
            sol_d   = '0;
            st_d    = mles_pkg::StZero;
            state_d = mles_pkg::SOut;
          end else begin
            quo_d   = mag_a;
            rem_d   = '0;
            dv_d    = mag_m;
            cnt_d   = '0;
            state_d = mles_pkg::SDivA;
          end
        end
      end

      mles_pkg::SDivA, mles_pkg::SDivB: begin
        quo_d = div_quo;
        rem_d = div_rem;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          cnt_d = '0;
          if (state_q == mles_pkg::SDivA) begin
            araw_d  = red_r;
            quo_d   = braw_q;
            rem_d   = '0;
            state_d = mles_pkg::SDivB;
          end else begin
            braw_d  = red_r;
            r0_d    = araw_q;
            r1_d    = m_q;
            s0_d    = (m_q == WIDTH'(1)) ? '0 : WIDTH'(1);
            s1_d    = '0;
            state_d = mles_pkg::SEucChk;
          end
        end
      end

      mles_pkg::SEucChk: begin
        quo_d = (r1_q == '0) ? braw_q : r0_q;
        dv_d  = (r1_q == '0) ? r0_q : r1_q;
        rem_d = '0;
        cnt_d = '0;
        state_d = (r1_q == '0) ? mles_pkg::SChkDiv : mles_pkg::SEucDiv;
      end

      mles_pkg::SEucDiv: begin
        quo_d = div_quo;
        rem_d = div_rem;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          cnt_d   = '0;
          r0_d    = r1_q;
          r1_d    = div_rem;
          mx_d    = qmod;
          my_d    = s1_q;
          acc_d   = '0;
          state_d = mles_pkg::SEucMul;
        end
      end

      mles_pkg::SEucMul, mles_pkg::SFinMul: begin
        if (my_q == '0) begin
          if (state_q == mles_pkg::SEucMul) begin
            s1_d    = sub_res[WIDTH-1:0];
            s0_d    = s1_q;
            state_d = mles_pkg::SEucChk;
          end else begin
            sol_d   = 31'(acc_q);
            st_d    = mles_pkg::StOk;
            state_d = mles_pkg::SOut;
          end
        end else begin
          if (my_q[0]) acc_d = acc_nx;
          mx_d = dbl_nx;
          my_d = my_q >> 1;
        end
      end

      mles_pkg::SChkDiv: begin
        quo_d = div_quo;
        rem_d = div_rem;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          cnt_d = '0;
          if (div_rem != '0) begin
            sol_d   = '0;
            st_d    = mles_pkg::StNone;
            state_d = mles_pkg::SOut;
          end else begin
            mx_d    = s0_q;
            my_d    = div_quo;
            acc_d   = '0;
            state_d = mles_pkg::SFinMul;
          end
        end
      end

      mles_pkg::SOut: begin
        rsp_o.valid = 1'b1;
        if (rsp_o.ready) state_d = mles_pkg::SIdle;
      end

      default: state_d = mles_pkg::SIdle;
    endcase
  end

  assign rsp_o.solution = sol_q;
  assign rsp_o.status   = st_q;

endmodule

### tb/modular_linear_equation_solver_test.sv
`timescale 1ns / 100ps

module modular_linear_equation_solver_test;

  localparam int unsigned LimitCycles = 6_000_000;
  localparam int unsigned NumRandom   = 290;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] m;
  } congruence_t;

  typedef struct packed {
    logic [30:0]       solution;
    mles_pkg::status_e status;
  } answer_t;

  logic clk_i;
  logic rst_ni;

  mles_req_if req_if ();
  mles_rsp_if rsp_if ();

  modular_linear_equation_solver u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // 12 ns period
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  congruence_t pending_q[$];
  answer_t     answers_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          stimulus_done = 1'b0;
  logic        req_fire;

  // Append one congruence to the stimulus queue
  function automatic void queue_item(congruence_t c);
    pending_q.insert(pending_q.size(), c);
  endfunction

  // Unsigned magnitude of a 32-bit two's complement value
  function automatic logic [63:0] magnitude32(logic [31:0] v);
    return {32'b0, v[31] ? (~v + 32'd1) : v};
  endfunction

  // Residue of a signed value in [0, m)
  function automatic logic [63:0] reduce_mod(logic [31:0] v, logic [63:0] m);
    logic [63:0] r;
    r = magnitude32(v) % m;
    if (v[31] && r != 0) r = m - r;
    return r;
  endfunction

  // Solve a*x = b (mod |m|) by extended Euclid, coefficient kept modulo m
  function automatic answer_t solve_congruence(congruence_t c);
    answer_t      ans;
    logic [63:0]  m, a, b, rem_hi, rem_lo, coef_hi, coef_lo, quot, tmp, gcd;
    logic [127:0] prod;
    ans = '{solution: '0, status: mles_pkg::StOk};
    m = magnitude32(c.m);
    if (m == 0) begin
      ans.status = mles_pkg::StZero;
      return ans;
    end
    a = reduce_mod(c.a, m);
    b = reduce_mod(c.b, m);
    rem_hi  = a;
    rem_lo  = m;
    coef_hi = 64'd1 % m;
    coef_lo = 0;
    while (rem_lo != 0) begin
      quot   = rem_hi / rem_lo;
      tmp    = rem_hi - quot * rem_lo;
      rem_hi = rem_lo;
      rem_lo = tmp;
      prod   = (128'(quot % m) * 128'(coef_lo)) % 128'(m);
      tmp    = (coef_hi >= prod[63:0]) ? coef_hi - prod[63:0] : coef_hi + (m - prod[63:0]);
      coef_hi = coef_lo;
      coef_lo = tmp;
    end
    gcd = rem_hi;
    if (b % gcd != 0) begin
      ans.status = mles_pkg::StNone;
      return ans;
    end
    prod = (128'(coef_hi) * 128'((b / gcd) % m)) % 128'(m);
    ans.solution = prod[30:0];
    return ans;
  endfunction

  function automatic logic [31:0] rand_modulus();
    logic [31:0] m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: m = $urandom_range(1, 60);
      4, 5:       m = $urandom_range(61, 100000);
      6:          m = $urandom_range(0, 3);
      default:    m = $urandom;
    endcase
    if ($urandom_range(0, 2) == 0) m = -m;
    return m;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  // Directed corners, then mostly solvable congruences with random content
  initial begin
    congruence_t c;
    logic [63:0] mm, xx;
    logic [127:0] p;
    queue_item('{32'd0, 32'd0, 32'd0});
    queue_item('{32'h7FFF_FFFF, 32'h8000_0000, 32'd0});
    queue_item('{32'd3, 32'd5, 32'h8000_0000});
    queue_item('{32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000});
    queue_item('{32'd12345, 32'd678, 32'd1});
    queue_item('{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
    queue_item('{32'd0, 32'd0, 32'd7});
    queue_item('{32'd14, 32'd21, 32'd7});
    queue_item('{32'd0, 32'd5, 32'd7});
    queue_item('{32'd2, 32'd1, 32'd4});
    queue_item('{32'd6, 32'd4, 32'd10});
    queue_item('{32'd3, 32'd1, -32'sd7});
    queue_item('{-32'sd3, -32'sd1, 32'd7});
    queue_item('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    queue_item('{32'h7FFF_FFFE, 32'h0000_0001, 32'h7FFF_FFFF});
    queue_item('{32'h8000_0000, 32'hFFFF_FFFF, -32'sd7});
    queue_item('{32'd1836311903, 32'd1, 32'h8000_0001});
    queue_item('{32'd1134903170, 32'd1836311903, 32'd1836311903});
    queue_item('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    queue_item('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0FFF_FFFF});
    for (int i = 0; i < NumRandom; i++) begin
      c.m = rand_modulus();
      c.a = rand_operand();
      c.b = rand_operand();
      mm  = magnitude32(c.m);
      // build a solvable right-hand side from a chosen x most of the time
      if ($urandom_range(0, 3) != 0 && mm != 0) begin
        xx  = $urandom % mm;
        p   = (128'(reduce_mod(c.a, mm)) * 128'(xx)) % 128'(mm);
        c.b = p[31:0];
        if ($urandom_range(0, 1)) c.b = c.b - mm[31:0];
      end
      queue_item(c);
    end
    stimulus_done = 1'b1;
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid   = 1'b0;
    req_if.coeff_a = '0;
    req_if.rhs_b   = '0;
    req_if.modulus = '0;
    rsp_if.ready   = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Sender: bursts of transactions with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && !req_fire) begin
        // hold until accepted
      end else if (gap_left > 0) begin
        req_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0) begin
        congruence_t c;
        c = pending_q.pop_front();
        req_if.valid   <= 1'b1;
        req_if.coeff_a <= c.a;
        req_if.rhs_b   <= c.b;
        req_if.modulus <= c.m;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 6);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall runs of random length, with long quiet stretches
  int unsigned stall_left = 0;
  int unsigned quiet_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (quiet_left > 0) begin
        rsp_if.ready <= 1'b1;
        quiet_left <= quiet_left - 1;
      end else if ($urandom_range(0, 1)) begin
        rsp_if.ready <= 1'b0;
        stall_left <= $urandom_range(0, 30);
      end else begin
        rsp_if.ready <= 1'b1;
        quiet_left <= $urandom_range(0, 3000);
      end
    end
  end

  // Monitor: record expectations on request transactions, check responses
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_fire <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      req_fire <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        answers_q.insert(answers_q.size(),
                         solve_congruence('{req_if.coeff_a, req_if.rhs_b, req_if.modulus}));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (answers_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected response: solution %0d status %0d",
                     rsp_if.solution, rsp_if.status);
        end else begin
          answer_t exp_ans;
          exp_ans = answers_q.pop_front();
          if (rsp_if.solution !== exp_ans.solution || rsp_if.status !== exp_ans.status) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("response mismatch: expected solution %0d status %0d, got %0d %0d",
                       exp_ans.solution, exp_ans.status, rsp_if.solution, rsp_if.status);
          end
        end
      end
    end
  end

  // End of run: all sent, all answered, then a drain for stray responses
  initial begin
    wait (rst_ni);
    wait (stimulus_done && pending_q.size() == 0 && !req_if.valid && answers_q.size() == 0);
    repeat (200) @(posedge clk_i);
    #1;
    if (mismatches == 0 && answers_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycles >= LimitCycles) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

### filelist.f
hw/rtl/mles_pkg.sv
hw/rtl/mles_if.sv
hw/rtl/modular_linear_equation_solver.sv
tb/modular_linear_equation_solver_test.sv
